>>> rtl/core/bcas_pkg.sv
// bcas_pkg: types, codes and reset constants of the beep-code alert sequencer.
// No dependencies; imported by the core modules, the checker and the bench.
`default_nettype none

package bcas_pkg;

  // queue geometry default
  localparam int QUEUE_DEPTH_DEF = 8;

  // register values after reset
  localparam logic [15:0] INTERVAL_RST = 16'd1000;
  localparam logic [15:0] LONG_RST     = 16'd500;
  localparam logic [15:0] SHORT_RST    = 16'd100;
  localparam logic [15:0] BETWEEN_RST  = 16'd100;
  localparam logic [15:0] AFTER_RST    = 16'd500;
  localparam logic [15:0] PWM_RST      = 16'd500;

  // queue entry codes: 1..4 motor number, 7 remote
  localparam logic [2:0] REMOTE_CODE   = 3'd7;
  localparam logic [7:0] MOTOR_NUM_MIN = 8'd1;
  localparam logic [7:0] MOTOR_NUM_MAX = 8'd4;
  localparam logic [15:0] TICK_SAT     = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_MOTOR  = 2'd1,
    CMD_REMOTE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BAD_ID = 3'd1,
    ST_FULL   = 3'd2,
    ST_DUP    = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_INTERVAL = 3'd0,
    REG_LONG     = 3'd1,
    REG_SHORT    = 3'd2,
    REG_BETWEEN  = 3'd3,
    REG_AFTER    = 3'd4,
    REG_PWM      = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LONG_ON  = 3'd1,
    PH_LONG_OFF = 3'd2,
    PH_SHORT_ON = 3'd3,
    PH_GAP      = 3'd4,
    PH_PAUSE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_SCAN_RD,
    SQ_SCAN_CMP,
    SQ_WRITE,
    SQ_POP_RD,
    SQ_POP,
    SQ_DONE
  } seq_state_t;

  // timing registers seen by the pattern player
  typedef struct packed {
    logic [15:0] long_ticks;
    logic [15:0] short_ticks;
    logic [15:0] between_ticks;
    logic [15:0] after_ticks;
  } pat_cfg_t;

  // sequencer to pattern player
  typedef struct packed {
    logic       tick;
    logic       start;
    logic [2:0] code;
  } pat_ctl_t;

  // pattern player to sequencer
  typedef struct packed {
    logic busy;
    logic on;
    logic finished;
  } pat_stat_t;

  // a zero beep length still lasts one tick
  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bcas_ifs.sv
// bcas_ifs: valid/ready channel interfaces for command words and result words.
// Depends on nothing but the port widths of the work item fields.
`default_nettype none

interface bcas_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] motor_num;

  modport source (output valid, output command, output motor_num, input ready);
  modport sink   (input valid, input command, input motor_num, output ready);
endinterface

interface bcas_rsp_if;
  logic        valid;
  logic        ready;
  logic        buzzer_on;
  logic [15:0] compare_value;
  logic [2:0]  request_status;
  logic [3:0]  queue_count;
  logic        busy_res;

  modport source (output valid, output buzzer_on, output compare_value,
                  output request_status, output queue_count, output busy_res,
                  input ready);
  modport sink   (input valid, input buzzer_on, input compare_value,
                  input request_status, input queue_count, input busy_res,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/bcas_pattern.sv
// bcas_pattern: beep pattern player, phase/timer/beep-count state machine.
// Depends on bcas_pkg.
`default_nettype none

module bcas_pattern (
  input  logic               clk,
  input  logic               rst,
  input  bcas_pkg::pat_cfg_t cfg,
  input  bcas_pkg::pat_ctl_t ctl,
  output bcas_pkg::pat_stat_t stat
);
  import bcas_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] timer, timer_next;
  logic [2:0]  beeps_left, beeps_left_next;
  logic        ends;
  logic [15:0] timer_dec;
  logic [2:0]  beeps_dec;

  assign timer_dec = timer - 16'd1;
  assign beeps_dec = beeps_left - 3'd1;

  // next phase, timer and beep count
  always_comb begin
    phase_next      = phase;
    timer_next      = timer;
    beeps_left_next = beeps_left;
    ends            = 1'b0;
    if (ctl.start) begin
      if (ctl.code == REMOTE_CODE) begin
        beeps_left_next = 3'd0;
        phase_next      = PH_LONG_ON;
        timer_next      = at_least_one(cfg.long_ticks);
      end else begin
        beeps_left_next = ctl.code;
        phase_next      = PH_SHORT_ON;
        timer_next      = at_least_one(cfg.short_ticks);
      end
    end else if (ctl.tick && phase != PH_IDLE) begin
      timer_next = timer_dec;
      if (timer_dec == 16'd0) begin
        unique case (phase)
          PH_LONG_ON: begin
            phase_next = PH_LONG_OFF;
            timer_next = at_least_one(cfg.long_ticks);
          end
          PH_SHORT_ON: begin
            beeps_left_next = beeps_dec;
            if (beeps_dec != 3'd0) begin
              if (cfg.between_ticks == 16'd0) begin
                phase_next = PH_SHORT_ON;
                timer_next = at_least_one(cfg.short_ticks);
              end else begin
                phase_next = PH_GAP;
                timer_next = cfg.between_ticks;
              end
            end else if (cfg.after_ticks == 16'd0) begin
              // zero pause: pattern ends on this tick
              phase_next = PH_IDLE;
              timer_next = 16'd0;
              ends       = 1'b1;
            end else begin
              phase_next = PH_PAUSE;
              timer_next = cfg.after_ticks;
            end
          end
          PH_GAP: begin
            phase_next = PH_SHORT_ON;
            timer_next = at_least_one(cfg.short_ticks);
          end
          default: begin
            phase_next = PH_IDLE;
            timer_next = 16'd0;
            ends       = 1'b1;
          end
        endcase
      end
    end
  end

  // status toward the sequencer
  always_comb begin
    stat.busy     = (phase != PH_IDLE);
    stat.on       = (phase == PH_LONG_ON) || (phase == PH_SHORT_ON);
    stat.finished = ends;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      timer      <= 16'd0;
      beeps_left <= 3'd0;
    end else begin
      phase      <= phase_next;
      timer      <= timer_next;
      beeps_left <= beeps_left_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/beep_code_alert_sequencer.sv
// beep_code_alert_sequencer: top level; alert queue memory, request sequencer,
// config registers. Depends on bcas_pkg, bcas_ifs and bcas_pattern.
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    command[1:0], motor_num[7:0]
//  rsp      out  valid/ready    buzzer_on, compare_value[15:0], request_status[2:0],
//                               queue_count[3:0], busy_res
//  wr_*     in   wr_en only     wr_index[2:0], wr_data[15:0]
//
// One word at a time. A tick goes from EXEC to DONE, and through POP_RD and
// POP on the way when it pops the queue head. A request that gets written goes
// through EXEC, a SCAN_RD/SCAN_CMP pair per queued entry that the duplicate scan
// reads through the single read port of the queue memory, WRITE and DONE; a bad
// id or a full queue goes from EXEC to DONE, and the scan ends at a duplicate.
// rst is synchronous; queue contents are not cleared, only fill count and pointers.
// A stalled result is held in the output register; the next word can be
// accepted meanwhile and waits in its last step until the register frees up.
`default_nettype none

module beep_code_alert_sequencer #(
  parameter int QUEUE_DEPTH = bcas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bcas_cmd_if.sink    cmd,
  bcas_rsp_if.source  rsp,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data
);
  import bcas_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FULL_CNT = FW'(QUEUE_DEPTH);

  // configuration registers
  logic [15:0] interval_ticks, long_beep_ticks, short_beep_ticks;
  logic [15:0] between_beep_ticks, after_beep_ticks, pwm_on_value;

  seq_state_t  state, state_next;
  logic [1:0]  cmd_reg;
  logic [7:0]  id_reg;
  logic [2:0]  code;
  status_t     status_reg;
  logic [PW-1:0] head, tail, scan_ptr, rd_addr;
  logic [FW-1:0] fill, scan_cnt;
  logic [15:0] ticks_since_end, tse_inc;
  logic [2:0]  mem [QUEUE_DEPTH];
  logic [2:0]  rd_data;
  logic        mem_we;
  logic        accept, rsp_free, id_bad, is_full, is_empty, pop_due, scan_hit, scan_last;

  pat_cfg_t  pcfg;
  pat_ctl_t  pctl;
  pat_stat_t pstat;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks     <= INTERVAL_RST;
      long_beep_ticks    <= LONG_RST;
      short_beep_ticks   <= SHORT_RST;
      between_beep_ticks <= BETWEEN_RST;
      after_beep_ticks   <= AFTER_RST;
      pwm_on_value       <= PWM_RST;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_INTERVAL: interval_ticks     <= wr_data;
        REG_LONG:     long_beep_ticks    <= wr_data;
        REG_SHORT:    short_beep_ticks   <= wr_data;
        REG_BETWEEN:  between_beep_ticks <= wr_data;
        REG_AFTER:    after_beep_ticks   <= wr_data;
        REG_PWM:      pwm_on_value       <= wr_data;
        default: ;
      endcase
    end
  end

  assign pcfg.long_ticks    = long_beep_ticks;
  assign pcfg.short_ticks   = short_beep_ticks;
  assign pcfg.between_ticks = between_beep_ticks;
  assign pcfg.after_ticks   = after_beep_ticks;

  // decodes
  assign accept    = cmd.valid && cmd.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign id_bad    = (id_reg < MOTOR_NUM_MIN) || (id_reg > MOTOR_NUM_MAX);
  assign is_full   = (fill == FULL_CNT);
  assign is_empty  = (fill == '0);
  assign tse_inc   = (ticks_since_end == TICK_SAT) ? TICK_SAT : ticks_since_end + 16'd1;
  assign pop_due   = (tse_inc >= interval_ticks) && !is_empty;
  assign scan_hit  = (rd_data == code);
  assign scan_last = (FW'(scan_cnt + FW'(1)) == fill);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      SQ_IDLE: if (accept) state_next = SQ_EXEC;
      SQ_EXEC: begin
        state_next = SQ_DONE;
        case (cmd_reg) inside
          CMD_TICK: if (!pstat.busy && pop_due) state_next = SQ_POP_RD;
          CMD_MOTOR, CMD_REMOTE: begin
            if ((cmd_reg == CMD_MOTOR && id_bad) || is_full) state_next = SQ_DONE;
            else if (is_empty) state_next = SQ_WRITE;
            else state_next = SQ_SCAN_RD;
          end
          default: state_next = SQ_DONE;
        endcase
      end
      SQ_SCAN_RD:  state_next = SQ_SCAN_CMP;
      SQ_SCAN_CMP: begin
        if (scan_hit) state_next = SQ_DONE;
        else if (scan_last) state_next = SQ_WRITE;
        else state_next = SQ_SCAN_RD;
      end
      SQ_WRITE:  state_next = SQ_DONE;
      SQ_POP_RD: state_next = SQ_POP;
      SQ_POP:    state_next = SQ_DONE;
      SQ_DONE:   if (rsp_free) state_next = SQ_IDLE;
      default:   state_next = SQ_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd.ready  = (state == SQ_IDLE);
    mem_we     = (state == SQ_WRITE);
    rd_addr    = (state == SQ_SCAN_RD) ? scan_ptr : head;
    pctl.tick  = (state == SQ_EXEC) && (cmd_reg == CMD_TICK) && pstat.busy;
    pctl.start = (state == SQ_POP);
    pctl.code  = rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SQ_IDLE;
    else     state <= state_next;
  end

  // queue memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[tail] <= code;
    rd_data <= mem[rd_addr];
  end

  // captured word and status
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg <= cmd.command;
      id_reg  <= cmd.motor_num;
    end
    unique case (state)
      SQ_EXEC: begin
        code       <= (cmd_reg == CMD_REMOTE) ? REMOTE_CODE : id_reg[2:0];
        scan_ptr   <= head;
        scan_cnt   <= '0;
        status_reg <= ST_NONE;
        if (cmd_reg == CMD_MOTOR && id_bad) status_reg <= ST_BAD_ID;
        else if ((cmd_reg == CMD_MOTOR || cmd_reg == CMD_REMOTE) && is_full)
          status_reg <= ST_FULL;
      end
      SQ_SCAN_CMP: begin
        scan_ptr <= ptr_inc(scan_ptr);
        scan_cnt <= FW'(scan_cnt + FW'(1));
        if (scan_hit) status_reg <= ST_DUP;
      end
      SQ_WRITE: status_reg <= ST_OK;
      default: ;
    endcase
  end

  // queue pointers, fill count and idle tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      head            <= '0;
      tail            <= '0;
      fill            <= '0;
      ticks_since_end <= 16'd0;
    end else begin
      if (state == SQ_WRITE) begin
        tail <= ptr_inc(tail);
        fill <= FW'(fill + FW'(1));
      end
      if (state == SQ_POP) begin
        head <= ptr_inc(head);
        fill <= FW'(fill - FW'(1));
      end
      if (state == SQ_EXEC && cmd_reg == CMD_TICK) begin
        if (!pstat.busy) ticks_since_end <= tse_inc;
        else if (pstat.finished) ticks_since_end <= 16'd0;
      end
    end
  end

  bcas_pattern u_pattern (
    .clk  (clk),
    .rst  (rst),
    .cfg  (pcfg),
    .ctl  (pctl),
    .stat (pstat)
  );

  // result register
  logic rsp_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == SQ_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == SQ_DONE && rsp_free) begin
      rsp.buzzer_on      <= pstat.on;
      rsp.compare_value  <= pstat.on ? pwm_on_value : 16'd0;
      rsp.request_status <= status_reg;
      rsp.queue_count    <= 4'(fill);
      rsp.busy_res       <= pstat.busy;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire

>>> rtl/core/bcas_checker.sv
// bcas_checker: port-level assertions for beep_code_alert_sequencer, and its bind.
// Depends on bcas_pkg.
`default_nettype none

module bcas_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        buzzer_on,
  input wire logic [15:0] compare_value,
  input wire logic [2:0]  request_status,
  input wire logic [3:0]  queue_count,
  input wire logic        busy_res
);
  import bcas_pkg::*;

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(buzzer_on) &&
      $stable(compare_value) && $stable(request_status) &&
      $stable(queue_count) && $stable(busy_res))
    else $error("result word changed while stalled");

  // one word in flight: no accept on the cycle after an accept
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted back to back");

  // sounding implies a pattern is playing
  a_on_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && buzzer_on |-> busy_res)
    else $error("buzzer on while idle");

  // silent buzzer drives a zero compare value
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !buzzer_on |-> compare_value == 16'd0)
    else $error("nonzero compare value while off");

  // a status code from the defined set
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> request_status == ST_OK || request_status == ST_BAD_ID ||
      request_status == ST_FULL || request_status == ST_DUP ||
      request_status == ST_NONE)
    else $error("undefined request status");

endmodule

bind beep_code_alert_sequencer bcas_checker u_bcas_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .buzzer_on      (rsp.buzzer_on),
  .compare_value  (rsp.compare_value),
  .request_status (rsp.request_status),
  .queue_count    (rsp.queue_count),
  .busy_res       (rsp.busy_res)
);

`default_nettype wire

>>> verif/beep_code_alert_sequencer_tb.sv
// beep_code_alert_sequencer_tb: self-checking bench for the beep-code alert sequencer.
// Drives command words and register writes, predicts every result word and checks it.
// Depends on bcas_pkg, bcas_ifs and the beep_code_alert_sequencer top level.

module beep_code_alert_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcas_pkg::*;

  // command code 3 is unused by the block and must be ignored
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_REGS = 6;
  localparam int NUM_DIRECTED = 28;
  localparam int NUM_PLANS = 9;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic        buzzer_on;
    logic [15:0] compare_value;
    status_t     request_status;
    logic [3:0]  queue_count;
    logic        busy_res;
  } rsp_word_t;

  typedef enum logic { ROW_WORD, ROW_WRITE } row_kind_t;

  // directed row: a command word or a register write; typed rows carry a fixed answer
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  command;
    logic [7:0]  motor_num;
    reg_idx_t    wr_index;
    logic [15:0] wr_data;
    logic        typed;
    status_t     want_status;
    logic [3:0]  want_count;
  } dir_row_t;

  // random phase: register setting, idling and length
  typedef struct packed {
    int              items;
    int              send_idle;
    int              recv_stall;
    logic            pressure;
    logic            ticks_only;
    logic [0:5][15:0] regs;
  } plan_t;

  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // after reset: interval 1000, nothing can start playing yet
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b1, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_UNUSED, 8'hFF, REG_INTERVAL, 16'd0,     1'b1, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_MOTOR,  8'h00, REG_INTERVAL, 16'd0,     1'b1, ST_BAD_ID, 4'd0},
    '{ROW_WORD,  CMD_MOTOR,  8'hFF, REG_INTERVAL, 16'd0,     1'b1, ST_BAD_ID, 4'd0},
    '{ROW_WORD,  CMD_MOTOR,  8'h05, REG_INTERVAL, 16'd0,     1'b1, ST_BAD_ID, 4'd0},
    '{ROW_WORD,  CMD_MOTOR,  8'h01, REG_INTERVAL, 16'd0,     1'b1, ST_OK,     4'd1},
    '{ROW_WORD,  CMD_MOTOR,  8'h01, REG_INTERVAL, 16'd0,     1'b1, ST_DUP,    4'd1},
    '{ROW_WORD,  CMD_REMOTE, 8'hAA, REG_INTERVAL, 16'd0,     1'b1, ST_OK,     4'd2},
    '{ROW_WORD,  CMD_REMOTE, 8'h55, REG_INTERVAL, 16'd0,     1'b1, ST_DUP,    4'd2},
    '{ROW_WORD,  CMD_MOTOR,  8'h04, REG_INTERVAL, 16'd0,     1'b1, ST_OK,     4'd3},
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b1, ST_NONE,   4'd3},
    // zero interval, zero-length beeps, gap and pause
    '{ROW_WRITE, CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WRITE, CMD_TICK,   8'h00, REG_SHORT,    16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WRITE, CMD_TICK,   8'h00, REG_BETWEEN,  16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WRITE, CMD_TICK,   8'h00, REG_AFTER,    16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WRITE, CMD_TICK,   8'h00, REG_LONG,     16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WRITE, CMD_TICK,   8'h00, REG_PWM,      16'hFFFF,  1'b0, ST_NONE,   4'd0},
    // play motor 1, the remote alert, then motor 4 with a request arriving mid-pattern
    '{ROW_WORD,  CMD_TICK,   8'hFF, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_MOTOR,  8'h02, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0},
    '{ROW_WORD,  CMD_TICK,   8'h00, REG_INTERVAL, 16'd0,     1'b0, ST_NONE,   4'd0}
  };

  // register order: interval, long, short, between, after, pwm
  localparam plan_t PLANS [NUM_PLANS] = '{
    '{200,   0,  0,  1'b0, 1'b0, '{16'd2, 16'd3, 16'd2, 16'd1, 16'd2, 16'h1234}},
    '{200,   85, 0,  1'b0, 1'b0, '{16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'h0000}},
    '{200,   0,  85, 1'b0, 1'b0, '{16'd5, 16'd0, 16'd0, 16'd3, 16'd1, 16'hFFFF}},
    '{200,   37, 37, 1'b0, 1'b0, '{16'd1, 16'd2, 16'd3, 16'd2, 16'd0, 16'hA5C3}},
    '{200,   0,  0,  1'b1, 1'b0, '{16'd0, 16'd1, 16'd2, 16'd0, 16'd3, 16'h7E81}},
    '{200,   37, 37, 1'b0, 1'b0, '{16'd3, 16'd4, 16'd1, 16'd1, 16'd5, 16'h00FF}},
    // empty the queue, then idle ticks that stay under the largest interval
    '{200,   0,  0,  1'b0, 1'b1, '{16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'hFF00}},
    '{60,    0,  0,  1'b0, 1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF}},
    '{40,    0,  0,  1'b0, 1'b0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF}}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [15:0] wr_data;

  bcas_cmd_if cmd_if();
  bcas_rsp_if rsp_if();

  beep_code_alert_sequencer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_if),
    .rsp      (rsp_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // own copy of the block's state and registers
  logic [15:0] cfg_regs [NUM_REGS] = '{INTERVAL_RST, LONG_RST, SHORT_RST, BETWEEN_RST,
                                       AFTER_RST, PWM_RST};
  logic [2:0]  alert_fifo [$];
  phase_t      play_phase = PH_IDLE;
  logic [2:0]  beeps_remaining = 3'd0;
  logic [15:0] phase_count = 16'd0;
  logic [15:0] idle_ticks = 16'd0;

  rsp_word_t   expected_words [$];
  rsp_word_t   pinned_word;
  logic        pinned_valid = 1'b0;
  rsp_word_t   got_word;
  rsp_word_t   want_word;
  int          mismatch_count = 0;
  int          word_index = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;

  // ---------------- prediction ----------------

  function automatic void end_pattern();
    play_phase = PH_IDLE;
    phase_count = 16'd0;
    idle_ticks = 16'd0;
  endfunction

  function automatic void start_beep();
    play_phase = PH_SHORT_ON;
    phase_count = (cfg_regs[REG_SHORT] == 16'd0) ? 16'd1 : cfg_regs[REG_SHORT];
  endfunction

  // phase timer ran out: move to the next phase of the pattern
  function automatic void close_phase();
    case (play_phase)
      PH_LONG_ON: begin
        play_phase = PH_LONG_OFF;
        phase_count = (cfg_regs[REG_LONG] == 16'd0) ? 16'd1 : cfg_regs[REG_LONG];
      end
      PH_SHORT_ON: begin
        beeps_remaining = beeps_remaining - 3'd1;
        if (beeps_remaining == 3'd0) begin
          if (cfg_regs[REG_AFTER] == 16'd0) begin
            end_pattern();
          end else begin
            play_phase = PH_PAUSE;
            phase_count = cfg_regs[REG_AFTER];
          end
        end else if (cfg_regs[REG_BETWEEN] == 16'd0) begin
          start_beep();
        end else begin
          play_phase = PH_GAP;
          phase_count = cfg_regs[REG_BETWEEN];
        end
      end
      PH_GAP: start_beep();
      default: end_pattern();
    endcase
  endfunction

  function automatic void tick_pattern();
    logic [2:0] code;
    if (play_phase != PH_IDLE) begin
      phase_count = phase_count - 16'd1;
      if (phase_count == 16'd0) close_phase();
    end else begin
      if (idle_ticks != TICK_SAT) idle_ticks = idle_ticks + 16'd1;
      if (idle_ticks >= cfg_regs[REG_INTERVAL] && alert_fifo.size() != 0) begin
        code = alert_fifo.pop_front();
        if (code == REMOTE_CODE) begin
          beeps_remaining = 3'd0;
          play_phase = PH_LONG_ON;
          phase_count = (cfg_regs[REG_LONG] == 16'd0) ? 16'd1 : cfg_regs[REG_LONG];
        end else begin
          beeps_remaining = code;
          start_beep();
        end
      end
    end
  endfunction

  // fullness first, then the duplicate scan
  function automatic status_t enqueue_alert(logic [2:0] code);
    if (alert_fifo.size() >= QUEUE_DEPTH_DEF) return ST_FULL;
    foreach (alert_fifo[i]) begin
      if (alert_fifo[i] == code) return ST_DUP;
    end
    alert_fifo.push_back(code);
    return ST_OK;
  endfunction

  function automatic rsp_word_t predict_word(logic [1:0] command, logic [7:0] id);
    status_t   st;
    logic      on;
    rsp_word_t w;
    st = ST_NONE;
    case (command)
      CMD_TICK: tick_pattern();
      CMD_MOTOR: begin
        if (id < MOTOR_NUM_MIN || id > MOTOR_NUM_MAX) st = ST_BAD_ID;
        else st = enqueue_alert(id[2:0]);
      end
      CMD_REMOTE: st = enqueue_alert(REMOTE_CODE);
      default: ;
    endcase
    on = (play_phase == PH_LONG_ON || play_phase == PH_SHORT_ON);
    w.buzzer_on = on;
    w.compare_value = on ? cfg_regs[REG_PWM] : 16'd0;
    w.request_status = st;
    w.queue_count = 4'(alert_fifo.size());
    w.busy_res = (play_phase != PH_IDLE);
    return w;
  endfunction

  // ---------------- checking ----------------

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("word %0d: %s", word_index, what);
  endfunction

  // register writes, accepted words and result words, all sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) cfg_regs[wr_index] = wr_data;
      if (cmd_if.valid && cmd_if.ready) begin
        want_word = predict_word(cmd_if.command, cmd_if.motor_num);
        expected_words.push_back(pinned_valid ? pinned_word : want_word);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got_word.buzzer_on = rsp_if.buzzer_on;
        got_word.compare_value = rsp_if.compare_value;
        got_word.request_status = status_t'(rsp_if.request_status);
        got_word.queue_count = rsp_if.queue_count;
        got_word.busy_res = rsp_if.busy_res;
        if (expected_words.size() == 0) begin
          note_mismatch("result word with nothing expected");
        end else begin
          want_word = expected_words.pop_front();
          if (got_word.buzzer_on !== want_word.buzzer_on ||
              got_word.compare_value !== want_word.compare_value ||
              got_word.request_status !== want_word.request_status ||
              got_word.queue_count !== want_word.queue_count ||
              got_word.busy_res !== want_word.busy_res)
            note_mismatch($sformatf(
              "want on=%0d cmp=%h st=%0d cnt=%0d busy=%0d, got on=%0d cmp=%h st=%0d cnt=%0d busy=%0d",
              want_word.buzzer_on, want_word.compare_value, want_word.request_status,
              want_word.queue_count, want_word.busy_res, got_word.buzzer_on,
              got_word.compare_value, got_word.request_status, got_word.queue_count,
              got_word.busy_res));
        end
        word_index++;
      end
    end
  end

  // ---------------- result side ----------------

  // random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------- command side ----------------

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(logic [1:0] command, logic [7:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.valid = 1'b1;
    cmd_if.command = command;
    cmd_if.motor_num = id;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // registers change only once every result word is back
  task automatic write_reg(reg_idx_t idx, logic [15:0] data);
    cmd_if.valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = data;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  initial begin
    int         pick;
    logic [1:0] command;
    logic [7:0] id;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_TICK;
    cmd_if.motor_num = 8'h00;
    wr_en = 1'b0;
    wr_index = REG_INTERVAL;
    wr_data = 16'd0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
        write_reg(DIRECTED_ROWS[i].wr_index, DIRECTED_ROWS[i].wr_data);
      end else begin
        pinned_valid = DIRECTED_ROWS[i].typed;
        pinned_word = '{buzzer_on: 1'b0, compare_value: 16'd0,
                        request_status: DIRECTED_ROWS[i].want_status,
                        queue_count: DIRECTED_ROWS[i].want_count, busy_res: 1'b0};
        send_word(DIRECTED_ROWS[i].command, DIRECTED_ROWS[i].motor_num);
      end
    end
    pinned_valid = 1'b0;

    // random phases: mostly ticks, with a steady trickle of requests unless ticks only
    for (int p = 0; p < NUM_PLANS; p++) begin
      for (int r = 0; r < NUM_REGS; r++) write_reg(reg_idx_t'(r), PLANS[p].regs[r]);
      send_idle_pct = PLANS[p].send_idle;
      recv_stall_pct = PLANS[p].recv_stall;
      if (PLANS[p].pressure) hold_request = HOLD_CYCLES;
      for (int n = 0; n < PLANS[p].items; n++) begin
        pick = PLANS[p].ticks_only ? 0 : $urandom_range(99);
        id = 8'($urandom);
        if (pick < 65) begin
          command = CMD_TICK;
        end else if (pick < 82) begin
          command = CMD_MOTOR;
          if ($urandom_range(9) != 0)
            id = 8'($urandom_range(MOTOR_NUM_MAX, MOTOR_NUM_MIN));
        end else if (pick < 96) begin
          command = CMD_REMOTE;
        end else begin
          command = CMD_UNUSED;
        end
        send_word(command, id);
      end
    end

    cmd_if.valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("beep_code_alert_sequencer: match");
    end else begin
      $display("beep_code_alert_sequencer: mismatch");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("beep_code_alert_sequencer: mismatch");
    $finish;
  end

endmodule
